### rtl/core/quaternion_to_euler_angles_top_defines.svh
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: assertion macros
// Checks compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_TOP_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define Q2E_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define Q2E_ASSERT_NR(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define Q2E_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define Q2E_ASSERT_NR(lbl, clk_s, prop, msg)
`endif
`endif

### rtl/core/q2e_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: package
// Widths, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none
package q2e_pkg;
    localparam int unsigned CORDIC_STAGES_DEF = 16;
    localparam int unsigned ATAN_LEN = 24;
    localparam int unsigned TERM_W = 18;
    localparam int unsigned ROOT_W = 18;
    // CORDIC datapath: 18 bit term scaled by 2^12, plus growth
    localparam int unsigned CW = 33;
    localparam int unsigned ZW = 34;
    localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
    localparam logic signed [15:0] ANGLE_LIM = 16'sd25736;

    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [CW-1:0] cval_t;
    typedef logic signed [ZW-1:0] zval_t;

    function automatic zval_t atan_tab(input int unsigned i);
        zval_t r;
        case (i)
            0: r = 34'sd843314857;  1: r = 34'sd497837829;
            2: r = 34'sd263043837;  3: r = 34'sd133525159;
            4: r = 34'sd67021687;   5: r = 34'sd33543516;
            6: r = 34'sd16775851;   7: r = 34'sd8388437;
            8: r = 34'sd4194283;    9: r = 34'sd2097149;
            10: r = 34'sd1048576;   11: r = 34'sd524288;
            12: r = 34'sd262144;    13: r = 34'sd131072;
            14: r = 34'sd65536;     15: r = 34'sd32768;
            16: r = 34'sd16384;     17: r = 34'sd8192;
            18: r = 34'sd4096;      19: r = 34'sd2048;
            20: r = 34'sd1024;      21: r = 34'sd512;
            22: r = 34'sd256;       23: r = 34'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

    // half-up round of sum/2^14 and clamp to 18 bits
    function automatic term_t make_term(input logic signed [33:0] s);
        logic signed [33:0] t;
        t = (s + 34'sd8192) >>> 14;
        if (t > 34'sd131071) return term_t'(18'sh1ffff);
        if (t < -34'sd131072) return term_t'(18'sh20000);
        return t[TERM_W-1:0];
    endfunction
endpackage
`default_nettype wire

### rtl/core/q2e_if.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: stream interfaces
// Valid/ready channels for quaternion requests and angle results.
// ----------------------------------------------------------------------------
`default_nettype none
interface q2e_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface q2e_out_if;
    logic valid;
    logic ready;
    logic signed [15:0] angle_about_x;
    logic signed [15:0] angle_about_y;
    logic signed [15:0] angle_about_z;
    logic gimbal_locked;
    modport source (output valid, angle_about_x, angle_about_y, angle_about_z,
                    gimbal_locked, input ready);
    modport sink (input valid, angle_about_x, angle_about_y, angle_about_z,
                  gimbal_locked, output ready);
endinterface
`default_nettype wire

### rtl/core/q2e_cordic.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: pipelined atan2
// Vectoring CORDIC, one register stage per iteration, Q3.13 rounded output.
// ----------------------------------------------------------------------------
`default_nettype none
module q2e_cordic #(
    parameter int unsigned CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic signed [q2e_pkg::ROOT_W:0] y_in,
    input  wire logic [q2e_pkg::ROOT_W:0] x_in,  // signed, one bit wider
    output logic signed [15:0]   angle
);
    localparam int unsigned NS = (CORDIC_STAGES < q2e_pkg::ATAN_LEN) ?
                                 CORDIC_STAGES : q2e_pkg::ATAN_LEN;

    q2e_pkg::cval_t x_reg [NS+1];
    q2e_pkg::cval_t y_reg [NS+1];
    q2e_pkg::zval_t z_reg [NS+1];
    logic           zero_reg [NS+1];

    // pre-rotation stage
    logic signed [q2e_pkg::ROOT_W:0] xs;
    logic signed [q2e_pkg::ROOT_W:0] ys;
    always_comb
    begin
        xs = $signed(x_in);
        ys = y_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (xs == '0) && (ys == '0);
            if (xs < 0)
            begin
                z_reg[0] <= (ys >= 0) ? q2e_pkg::PI_Q30 : -q2e_pkg::PI_Q30;
                x_reg[0] <= q2e_pkg::cval_t'(-xs) <<< 12;
                y_reg[0] <= q2e_pkg::cval_t'(-ys) <<< 12;
            end
            else
            begin
                z_reg[0] <= '0;
                x_reg[0] <= q2e_pkg::cval_t'(xs) <<< 12;
                y_reg[0] <= q2e_pkg::cval_t'(ys) <<< 12;
            end
        end
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] < 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - q2e_pkg::atan_tab(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + q2e_pkg::atan_tab(i);
                end
            end
        end
    end

    logic signed [q2e_pkg::ZW-1:0] r;
    always_comb
    begin
        r = (z_reg[NS] + q2e_pkg::zval_t'(65536)) >>> 17;
        if (zero_reg[NS])
            angle = '0;
        else if (r > q2e_pkg::zval_t'(q2e_pkg::ANGLE_LIM))
            angle = q2e_pkg::ANGLE_LIM;
        else if (r < -q2e_pkg::zval_t'(q2e_pkg::ANGLE_LIM))
            angle = -q2e_pkg::ANGLE_LIM;
        else
            angle = r[15:0];
    end
endmodule
`default_nettype wire

### rtl/core/quaternion_to_euler_angles_top.sv
// Throughput: one request per cycle; the whole pipeline advances together and
// halts only when the output register is full and not taken.
// Square root is a 9-stage restoring pipeline, two result bits per stage.
// Reset (rst_n low, asynchronous) clears valid bits and sets the threshold register thr_reg to 1.
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: top level
// Matrix terms, square root, three CORDIC atan2 pipelines, output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quaternion_to_euler_angles_top_defines.svh"
module quaternion_to_euler_angles_top #(
    parameter int unsigned CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic [15:0] cfg_wdata,
    q2e_in_if.sink     in_req,
    q2e_out_if.source  out_res
);
    localparam int unsigned NS = (CORDIC_STAGES < q2e_pkg::ATAN_LEN) ?
                                 CORDIC_STAGES : q2e_pkg::ATAN_LEN;
    localparam int unsigned SQ = 9;     // square root stages
    localparam int unsigned PRE = 4;    // product, term, square, sum
    // CORDIC entry stage plus NS iterations; output register comes after
    localparam int unsigned DEPTH = PRE + SQ + NS + 1;

    logic [15:0] thr_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) thr_reg <= 16'd1;
        else if (cfg_we) thr_reg <= cfg_wdata;
    end

    // one enable for the whole pipeline; valid bits ride alongside
    logic en;
    logic [DEPTH-1:0] vld_reg;
    assign en = !out_res.valid || out_res.ready;
    assign in_req.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[DEPTH-2:0], in_req.valid};
    end

    // stage 1: products
    logic signed [31:0] xx_reg, yy_reg, zz_reg, xz_reg, yw_reg, yz_reg, xw_reg,
                        xy_reg, zw_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg <= in_req.quat_x * in_req.quat_x;
            yy_reg <= in_req.quat_y * in_req.quat_y;
            zz_reg <= in_req.quat_z * in_req.quat_z;
            xz_reg <= in_req.quat_x * in_req.quat_z;
            yw_reg <= in_req.quat_y * in_req.quat_w;
            yz_reg <= in_req.quat_y * in_req.quat_z;
            xw_reg <= in_req.quat_x * in_req.quat_w;
            xy_reg <= in_req.quat_x * in_req.quat_y;
            zw_reg <= in_req.quat_z * in_req.quat_w;
        end
    end

    // stage 2: matrix terms, both branches formed
    localparam logic signed [33:0] ONE_Q29 = 34'sd536870912;
    q2e_pkg::term_t m31_reg, m32_reg, m33_reg, m12_reg, m22_reg, m11_reg, m21_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m31_reg <= q2e_pkg::make_term(34'(xz_reg) + 34'(yw_reg));
            m32_reg <= q2e_pkg::make_term(34'(yz_reg) - 34'(xw_reg));
            m33_reg <= q2e_pkg::make_term(ONE_Q29 - 34'(xx_reg) - 34'(yy_reg));
            m12_reg <= q2e_pkg::make_term(34'(xy_reg) + 34'(zw_reg));
            m22_reg <= q2e_pkg::make_term(ONE_Q29 - 34'(xx_reg) - 34'(zz_reg));
            m11_reg <= q2e_pkg::make_term(ONE_Q29 - 34'(yy_reg) - 34'(zz_reg));
            m21_reg <= q2e_pkg::make_term(34'(xy_reg) - 34'(zw_reg));
        end
    end

    typedef struct packed {
        q2e_pkg::term_t m31, m32, m33, m12, m22, m11, m21;
    } terms_t;

    // stage 3: squares; stage 4: sum
    terms_t t3_reg, t4_reg;
    logic [35:0] s33_reg, s31_reg;
    logic [36:0] ssum_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t3_reg <= '{m31_reg, m32_reg, m33_reg, m12_reg, m22_reg, m11_reg, m21_reg};
            s33_reg <= 36'(m33_reg * m33_reg);
            s31_reg <= 36'(m31_reg * m31_reg);
            t4_reg <= t3_reg;
            ssum_reg <= {1'b0, s33_reg} + {1'b0, s31_reg};
        end
    end

    // square root, two result bits per stage (restoring, 18 bit root)
    terms_t        tq_reg   [SQ+1];
    logic [36:0]   rem_reg  [SQ+1];
    logic [17:0]   root_reg [SQ+1];
    always_comb
    begin
        tq_reg[0] = t4_reg;
        rem_reg[0] = ssum_reg;
        root_reg[0] = '0;
    end
    for (genvar k = 0; k < SQ; k++)
    begin : g_sqrt
        logic [36:0] rem_a, rem_b;
        logic [17:0] rt_a, rt_b;
        logic [36:0] trial_a, trial_b;
        localparam int unsigned BA = 17 - 2*k;
        localparam int unsigned BB = 16 - 2*k;
        always_comb
        begin
            trial_a = 37'((37'(root_reg[k]) << (BA + 1)) | (37'd1 << (2*BA)));
            if (rem_reg[k] >= trial_a)
            begin
                rem_a = rem_reg[k] - trial_a;
                rt_a = root_reg[k] | (18'd1 << BA);
            end
            else
            begin
                rem_a = rem_reg[k];
                rt_a = root_reg[k];
            end
            trial_b = 37'((37'(rt_a) << (BB + 1)) | (37'd1 << (2*BB)));
            if (rem_a >= trial_b)
            begin
                rem_b = rem_a - trial_b;
                rt_b = rt_a | (18'd1 << BB);
            end
            else
            begin
                rem_b = rem_a;
                rt_b = rt_a;
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tq_reg[k+1] <= tq_reg[k];
                rem_reg[k+1] <= rem_b;
                root_reg[k+1] <= rt_b;
            end
        end
    end

    terms_t      tf;
    logic [17:0] root;
    logic        lock;
    assign tf = tq_reg[SQ];
    assign root = root_reg[SQ];
    assign lock = root <= 18'(thr_reg);

    // negate with saturation-free widening: -(-131072) fits 19 bits
    logic signed [18:0] nm32, nm21;
    assign nm32 = -{tf.m32[17], tf.m32};
    assign nm21 = -{tf.m21[17], tf.m21};

    // atan2 operands, all 19 bit signed
    logic signed [18:0] ax_y, az_y, ay_y;
    logic [18:0]        ax_x, ay_x, az_x;
    always_comb
    begin
        ax_y = nm32;
        ax_x = {1'b0, root};
        ay_y = {tf.m31[17], tf.m31};
        ay_x = {tf.m33[17], tf.m33};
        if (lock)
        begin
            az_y = nm21;
            az_x = {tf.m11[17], tf.m11};
        end
        else
        begin
            az_y = {tf.m12[17], tf.m12};
            az_x = {tf.m22[17], tf.m22};
        end
    end

    // flag and lock path delay matches the CORDIC depth
    logic lock_d_reg [NS+1];
    always_ff @(posedge clk)
    begin
        if (en) lock_d_reg[0] <= lock;
    end
    for (genvar j = 0; j < NS; j++)
    begin : g_lk
        always_ff @(posedge clk)
        begin
            if (en) lock_d_reg[j+1] <= lock_d_reg[j];
        end
    end

    logic signed [15:0] ang_x, ang_y, ang_z;
    q2e_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cx (
        .clk(clk), .en(en), .y_in(ax_y), .x_in(ax_x), .angle(ang_x));
    q2e_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cy (
        .clk(clk), .en(en), .y_in(ay_y), .x_in(ay_x), .angle(ang_y));
    q2e_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cz (
        .clk(clk), .en(en), .y_in(az_y), .x_in(az_x), .angle(ang_z));

    // output register
    logic out_v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_v_reg <= 1'b0;
        else if (en) out_v_reg <= vld_reg[DEPTH-1];
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_res.angle_about_x <= ang_x;
            out_res.angle_about_y <= lock_d_reg[NS] ? 16'sd0 : ang_y;
            out_res.angle_about_z <= ang_z;
            out_res.gimbal_locked <= lock_d_reg[NS];
        end
    end
    assign out_res.valid = out_v_reg;

    `Q2E_ASSERT(a_stall_hold, clk, rst_n, out_res.valid && !out_res.ready |=> out_res.valid, "result dropped under stall")
    `Q2E_ASSERT(a_ready, clk, rst_n, in_req.ready == (!out_res.valid || out_res.ready), "ready mismatch")
    `Q2E_ASSERT(a_lock_y, clk, rst_n, out_res.valid && out_res.gimbal_locked |-> out_res.angle_about_y == 16'sd0, "y angle nonzero in lock")
endmodule
`default_nettype wire

### sim/quaternion_to_euler_angles_top_tb.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: top-level testbench
// Drives quaternion requests with random gaps and back-pressure. Each accepted
// request is scored against an in-bench fixed-point angle predictor, under
// several gimbal threshold settings.
// ----------------------------------------------------------------------------
`default_nettype none
module quaternion_to_euler_angles_top_tb;

    localparam int unsigned STAGES = q2e_pkg::CORDIC_STAGES_DEF;
    localparam int DRAIN_CYCLES = 4 + 9 + STAGES + 2 + 10;  // latency plus margin
    localparam int IDLE_LIMIT = 5000;  // cycles with no handshake on either side
    localparam int HOLD_CYCLES = 300;  // long receiver stall to fill the pipeline
    localparam int RAND_PER_PHASE = 240;
    localparam longint PI_FX = 64'sd3373259426;  // pi in Q30
    localparam longint LIM_FX = 64'sd25736;      // angle clamp, Q3.13

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic               lock;
    } angles_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
        logic               typed;     // lock flag below is given by hand
        logic               exp_lock;
    } quat_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    q2e_in_if  req_if();
    q2e_out_if res_if();

    quaternion_to_euler_angles_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_req    (req_if),
        .out_res   (res_if)
    );

    // Bench copy of the threshold register
    logic [15:0] thr_shadow;
    angles_t     angle_fifo[$];
    int          err_cnt;
    int          req_cnt;
    int          res_cnt;
    int          lock_cnt;
    int          idle_cnt;
    logic        no_gaps;   // phases with back-to-back traffic on both sides

    // ------------------------------------------------------------------------
    // Clock: period 10
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------------
    // half-up round of a product sum to 2^-15 units, saturated to 18 bits
    function automatic longint round_term(input longint s);
        longint t;
        t = (s + 64'sd8192) >>> 14;
        if (t > 64'sd131071) t = 64'sd131071;
        if (t < -64'sd131072) t = -64'sd131072;
        return t;
    endfunction

    // floor of the square root, by bisection
    function automatic longint floor_root(input longint v);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 64'sd4194304;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) / 2;
            if (mid * mid <= v) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    // vectoring CORDIC atan2(y, x), angle returned in Q3.13
    function automatic logic signed [15:0] cordic_angle(input longint y, input longint x);
        longint acc;
        longint dx;
        longint dy;
        longint r;
        if (x == 0 && y == 0) return '0;
        acc = 0;
        if (x < 0)
        begin
            // move to right half-plane, preload +/- pi
            acc = (y >= 0) ? PI_FX : -PI_FX;
            x = -x;
            y = -y;
        end
        x = x * 4096;
        y = y * 4096;
        for (int i = 0; i < STAGES && i < q2e_pkg::ATAN_LEN; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0)
            begin
                x = x - dx;
                y = y + dy;
                acc = acc - longint'(q2e_pkg::atan_tab(i));
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                acc = acc + longint'(q2e_pkg::atan_tab(i));
            end
        end
        r = (acc + 64'sd65536) >>> 17;
        if (r > LIM_FX) r = LIM_FX;
        if (r < -LIM_FX) r = -LIM_FX;
        return r[15:0];
    endfunction

    function automatic angles_t euler_angles(input quat_row_t q);
        angles_t a;
        longint qx, qy, qz, qw;
        longint m11, m12, m21, m22, m31, m32, m33, root;
        qx = q.x; qy = q.y; qz = q.z; qw = q.w;
        m31 = round_term(qx * qz + qy * qw);
        m32 = round_term(qy * qz - qx * qw);
        m33 = round_term(64'sd536870912 - qx * qx - qy * qy);
        root = floor_root(m33 * m33 + m31 * m31);
        a.ax = cordic_angle(-m32, root);
        if (root > longint'(thr_shadow))
        begin
            m12 = round_term(qx * qy + qz * qw);
            m22 = round_term(64'sd536870912 - qx * qx - qz * qz);
            a.ay = cordic_angle(m31, m33);
            a.az = cordic_angle(m12, m22);
            a.lock = 1'b0;
        end
        else
        begin
            // gimbal lock: y angle pinned to zero, z from the other column
            m11 = round_term(64'sd536870912 - qy * qy - qz * qz);
            m21 = round_term(qx * qy - qz * qw);
            a.ay = '0;
            a.az = cordic_angle(-m21, m11);
            a.lock = 1'b1;
        end
        return a;
    endfunction

    task automatic report(input string what, input int got, input int want);
        err_cnt++;
        if (err_cnt <= 40)
            $display("MISMATCH %s: got %0d, want %0d (result %0d)", what, got, want, res_cnt);
    endtask

    // ------------------------------------------------------------------------
    // Scoreboard: requests are predicted as they are taken, results popped
    // ------------------------------------------------------------------------
    quat_row_t cur_row;   // row being offered by the sender

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
            begin
                angles_t e;
                e = euler_angles(cur_row);
                if (cur_row.typed)
                begin
                    e.lock = cur_row.exp_lock;
                    if (cur_row.exp_lock) e.ay = '0;
                end
                angle_fifo.push_back(e);
                req_cnt++;
            end
            if (res_if.valid && res_if.ready)
            begin
                if (angle_fifo.size() == 0)
                    report("unexpected result", 0, 0);
                else
                begin
                    angles_t e;
                    e = angle_fifo.pop_front();
                    if (res_if.angle_about_x !== e.ax)
                        report("angle_about_x", res_if.angle_about_x, e.ax);
                    if (res_if.angle_about_y !== e.ay)
                        report("angle_about_y", res_if.angle_about_y, e.ay);
                    if (res_if.angle_about_z !== e.az)
                        report("angle_about_z", res_if.angle_about_z, e.az);
                    if (res_if.gimbal_locked !== e.lock)
                        report("gimbal_locked", res_if.gimbal_locked, e.lock);
                    if (e.lock) lock_cnt++;
                end
                res_cnt++;
            end
        end
    end

    // Watchdog: no handshake on either channel for too long ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                idle_cnt <= 0;
            else
                idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= IDLE_LIMIT)
            begin
                $display("timeout: %0d requests, %0d results", req_cnt, res_cnt);
                $display("quaternion_to_euler_angles_top_tb: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, plus one long hold to back the pipe up
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        int taken;
        taken = 0;
        res_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 9);
            if (taken == 100)
                stall = HOLD_CYCLES;
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid) @(posedge clk);
            taken++;
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    task automatic send_quat(input quat_row_t q);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid  <= 1'b1;
        req_if.quat_x <= q.x;
        req_if.quat_y <= q.y;
        req_if.quat_z <= q.z;
        req_if.quat_w <= q.w;
        cur_row <= q;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
    endtask

    // drain all outstanding results, then let the pipe settle before a write
    task automatic settle();
        req_if.valid <= 1'b0;
        while (angle_fifo.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        thr_shadow = v;
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return -16'sd1;
            3: return 16'sd1;
            4: return 16'sd23170;
            default: return 16'sd0;
        endcase
    endfunction

    function automatic logic signed [15:0] small_noise(input int amp);
        return 16'($signed($urandom_range(0, 2 * amp)) - amp);
    endfunction

    // Random quaternion: mostly full range, some near gimbal lock, some extremes
    function automatic quat_row_t random_quat();
        quat_row_t q;
        int kind;
        int amp;
        q = '0;
        kind = $urandom_range(0, 9);
        if (kind < 5)
        begin
            q.x = 16'($urandom); q.y = 16'($urandom);
            q.z = 16'($urandom); q.w = 16'($urandom);
        end
        else if (kind < 8)
        begin
            // pitch near +/-90 deg: y near 1/sqrt2, rest small; sometimes x, z raised, y halved
            amp = ($urandom_range(0, 1) == 1) ? 4 : 300;
            q.x = small_noise(amp);
            q.y = small_noise(amp);
            q.z = small_noise(amp);
            q.w = small_noise(amp);
            if ($urandom_range(0, 1) == 1) q.y = q.y + 16'sd23170;
            else q.y = q.y - 16'sd23170;
            if ($urandom_range(0, 3) == 0)
            begin
                q.x = q.x + 16'sd16384; q.y = q.y / 2; q.z = q.z + 16'sd16384;
            end
        end
        else
        begin
            q.x = pick_extreme(); q.y = pick_extreme();
            q.z = pick_extreme(); q.w = pick_extreme();
        end
        return q;
    endfunction

    // Directed rows: extremes, identity, axis rotations, gimbal lock both ways
    quat_row_t directed_rows[] = '{
        '{16'sd0,      16'sd0,      16'sd0,      16'sd0,      1'b1, 1'b0},
        '{16'sd0,      16'sd0,      16'sd0,      16'sd32767,  1'b1, 1'b0},
        '{16'sd0,      16'sd0,      16'sd0,      -16'sd32768, 1'b1, 1'b0},
        '{16'sd32767,  16'sd0,      16'sd0,      16'sd0,      1'b0, 1'b0},
        '{16'sd0,      16'sd32767,  16'sd0,      16'sd0,      1'b0, 1'b0},
        '{16'sd0,      16'sd0,      16'sd32767,  16'sd0,      1'b0, 1'b0},
        '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 1'b0},
        '{16'sd32767,  16'sd32767,  16'sd32767,  16'sd32767,  1'b0, 1'b0},
        '{16'sd32767,  -16'sd32768, 16'sd32767,  -16'sd32768, 1'b0, 1'b0},
        '{16'sd0,      16'sd23170,  16'sd0,      16'sd0,      1'b1, 1'b1},
        '{16'sd0,      -16'sd23170, 16'sd0,      16'sd0,      1'b1, 1'b1},
        '{16'sd16384,  16'sd16384,  16'sd16384,  16'sd16384,  1'b0, 1'b0},
        '{16'sd16384,  -16'sd16384, 16'sd16384,  16'sd16384,  1'b0, 1'b0},
        '{16'sd23170,  16'sd0,      16'sd0,      16'sd23170,  1'b0, 1'b0},
        '{16'sd0,      16'sd0,      16'sd23170,  -16'sd23170, 1'b0, 1'b0},
        '{-16'sd1,     16'sd1,      -16'sd1,     16'sd1,      1'b0, 1'b0},
        '{16'sd100,    -16'sd23170, 16'sd50,     16'sd3,      1'b0, 1'b0},
        '{-16'sd23170, 16'sd0,      16'sd23170,  16'sd0,      1'b0, 1'b0}
    };

    // Threshold settings after the reset value: extremes and in-between
    logic [15:0] thr_steps[] = '{16'd0, 16'd65535, 16'd1000, 16'd32768, 16'd1};

    initial
    begin
        quat_row_t q;
        err_cnt = 0; req_cnt = 0; res_cnt = 0; lock_cnt = 0;
        idle_cnt = 0;
        thr_shadow = 16'd1;
        no_gaps = 1'b0;
        cur_row = '0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        req_if.valid <= 1'b0;
        req_if.quat_x <= '0;
        req_if.quat_y <= '0;
        req_if.quat_z <= '0;
        req_if.quat_w <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset threshold
        foreach (directed_rows[i])
            send_quat(directed_rows[i]);

        // random phases, one per threshold setting
        foreach (thr_steps[p])
        begin
            settle();
            write_threshold((p == 3) ? 16'($urandom) : thr_steps[p]);
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                // every phase has a stretch of back-to-back traffic
                no_gaps = (n >= 150 && n < 190);
                q = random_quat();
                send_quat(q);
            end
            no_gaps = 1'b0;
        end

        settle();
        $display("%0d requests, %0d results, %0d in gimbal lock, %0d threshold settings",
                 req_cnt, res_cnt, lock_cnt, thr_steps.size() + 1);
        if (err_cnt == 0 && angle_fifo.size() == 0)
            $display("quaternion_to_euler_angles_top_tb: clean");
        else
            $display("quaternion_to_euler_angles_top_tb: errors");
        $finish;
    end
endmodule
`default_nettype wire
